// ===== src/bis_pkg.sv =====
// Shared constants and types for the batch insertion sorter.
`default_nettype none

package bis_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CntW     = $clog2(CAPACITY + 1);

  typedef logic signed [31:0] value_t;
  typedef logic [CntW-1:0]    cnt_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/bis_cell.sv =====
// One sorter cell: holds a value, compares it to the incoming key and shifts.
`default_nettype none

module bis_cell
  import bis_pkg::*;
(
  input  wire        clk_i,
  input  cell_ctrl_t ctrl_i,
  input  wire        held_i,
  input  value_t     ins_val_i,
  input  wire        prev_move_i,
  input  value_t     prev_val_i,
  input  value_t     next_val_i,
  output logic       move_o,
  output value_t     val_o
);

  value_t val_q;
  value_t val_d;

  // Cell is displaced when empty or when its value is strictly greater.
  assign move_o = !held_i || (val_q > ins_val_i);
  assign val_o  = val_q;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.pop) begin
      val_d = next_val_i;
    end else if (ctrl_i.insert && move_o) begin
      val_d = prev_move_i ? prev_val_i : ins_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

`default_nettype wire

// ===== src/batch_insertion_sorter.sv =====
// Batch insertion sorter: a row of cells that sorts each batch and drains it in order.
//
// Input channel (in_valid_i/in_ready_o, value_i, batch_end_i): one signed value per
// transaction. Every cell compares against the new value in parallel and the
// greater entries shift up one place, so one value is taken each cycle while a
// batch is being loaded. Values past CAPACITY are dropped and flagged.
// A transaction with batch_end_i set closes the batch; in_ready_o then drops
// and the batch drains from the bottom cell, one result per cycle while the
// receiver takes them, through an output register (out_valid_o/out_ready_i).
// After the closing transaction the drain flag is registered, then the first
// result is popped into the output register. last_out_o marks the final result and
// overflowed_o is set on every result of a batch that dropped values.
// A stalled receiver holds the output register and freezes the drain. The next
// batch is taken as soon as the last result enters the output register, even
// while that result still waits.
// Reset empties the batch, clears the overflow flag and the output valid flag.
`default_nettype none

module batch_insertion_sorter
  import bis_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [31:0] value_i,
  input  wire         batch_end_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [31:0] sorted_value_o,
  output logic        last_out_o,
  output logic        overflowed_o
);

  cnt_t   cnt_q, cnt_d;
  logic   drain_q, drain_d;
  logic   ovf_q, ovf_d;
  logic   out_valid_q, out_valid_d;
  value_t out_val_q;
  logic   out_last_q;
  logic   out_ovf_q;

  logic       in_fire;
  logic       full;
  logic       pop;
  cell_ctrl_t ctrl;

  logic   [CAPACITY-1:0] move;
  value_t                cell_val [CAPACITY];

  assign in_ready_o = !drain_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign full       = (cnt_q == cnt_t'(CAPACITY));
  assign pop        = drain_q && (!out_valid_q || out_ready_i) && (cnt_q != '0);

  assign ctrl.insert = in_fire && !full;
  assign ctrl.pop    = pop;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   prev_move;
    value_t prev_val;
    value_t next_val;

    if (i == 0) begin : g_first
      assign prev_move = 1'b0;
      assign prev_val  = '0;
    end else begin : g_mid
      assign prev_move = move[i-1];
      assign prev_val  = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_val = '0;
    end else begin : g_inner
      assign next_val = cell_val[i+1];
    end

    bis_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .held_i      (cnt_q > cnt_t'(i)),
      .ins_val_i   (value_t'(value_i)),
      .prev_move_i (prev_move),
      .prev_val_i  (prev_val),
      .next_val_i  (next_val),
      .move_o      (move[i]),
      .val_o       (cell_val[i])
    );
  end

  always_comb begin
    cnt_d       = cnt_q;
    drain_d     = drain_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_fire) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        cnt_d = cnt_q + cnt_t'(1);
      end
      if (batch_end_i) begin
        drain_d = 1'b1;
      end
    end
    if (pop) begin
      out_valid_d = 1'b1;
      cnt_d       = cnt_q - cnt_t'(1);
      if (cnt_q == cnt_t'(1)) begin
        drain_d = 1'b0;
        ovf_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      drain_q     <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      drain_q     <= drain_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_val_q  <= cell_val[0];
      out_last_q <= (cnt_q == cnt_t'(1));
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_val_q;
  assign last_out_o     = out_last_q;
  assign overflowed_o   = out_ovf_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cnt_t'(CAPACITY))
    else $error("fill count beyond capacity");

  a_pop_only_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> drain_q && !in_fire)
    else $error("pop outside drain or alongside input transaction");

  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && cnt_q == cnt_t'(1)) |=> !drain_q && cnt_q == '0 && !ovf_q && out_last_q)
    else $error("final pop did not close the batch");

  a_no_drain_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !batch_end_i) |=> !drain_q)
    else $error("drain started without batch end");

endmodule

`default_nettype wire

// ===== tb/sv/sorted_batch_checker.sv =====
// Checker for the batch insertion sorter: keeps its own ordered batch and compares results.
module sorted_batch_checker (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  logic   in_ready_i,
  input  bis_pkg::value_t value_i,
  input  logic   batch_end_i,
  input  logic   out_valid_i,
  input  logic   out_ready_i,
  input  bis_pkg::value_t sorted_value_i,
  input  logic   last_out_i,
  input  logic   overflowed_i,
  output int     mismatch_count_o,
  output int     due_count_o,
  output int     checked_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import bis_pkg::*;

  typedef struct packed {
    value_t key;
    logic   is_last;
    logic   ovf;
  } sorted_res_t;

  value_t      held_vals [CAPACITY];
  int unsigned held_n;
  logic        dropped;
  sorted_res_t sorted_due [$];
  int          mismatches;
  int          checked;

  initial begin
    mismatch_count_o = 0;
    due_count_o      = 0;
    checked_count_o  = 0;
    mismatches       = 0;
    checked          = 0;
    held_n           = 0;
    dropped          = 1'b0;
  end

  // stable insert: new value lands after every held value <= it
  function automatic void insert_ordered(input value_t v);
    int unsigned pos;
    pos = held_n;
    if (held_n >= CAPACITY) begin
      dropped = 1'b1;
      return;
    end
    while (pos > 0 && held_vals[pos-1] > v) begin
      held_vals[pos] = held_vals[pos-1];
      pos--;
    end
    held_vals[pos] = v;
    held_n++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    sorted_res_t exp_r;
    sorted_res_t item_r;
    if (!rst_ni) begin
      held_n  = 0;
      dropped = 1'b0;
      sorted_due.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (sorted_due.size() == 0) begin
          $display("%0t unexpected result: expected none, got value %0d last %0b ovf %0b",
                   $time, sorted_value_i, last_out_i, overflowed_i);
          mismatches++;
        end else begin
          exp_r = sorted_due.pop_front();
          checked++;
          if (sorted_value_i !== exp_r.key) begin
            $display("%0t sorted_value mismatch: expected %0d, got %0d",
                     $time, exp_r.key, sorted_value_i);
            mismatches++;
          end
          if (last_out_i !== exp_r.is_last) begin
            $display("%0t last_out mismatch: expected %0b, got %0b",
                     $time, exp_r.is_last, last_out_i);
            mismatches++;
          end
          if (overflowed_i !== exp_r.ovf) begin
            $display("%0t overflowed mismatch: expected %0b, got %0b",
                     $time, exp_r.ovf, overflowed_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        insert_ordered(value_i);
        if (batch_end_i) begin
          for (int unsigned k = 0; k < held_n; k++) begin
            item_r.key     = held_vals[k];
            item_r.is_last = (k + 1 == held_n);
            item_r.ovf     = dropped;
            sorted_due.push_back(item_r);
          end
          held_n  = 0;
          dropped = 1'b0;
        end
      end
    end
    mismatch_count_o <= mismatches;
    due_count_o      <= sorted_due.size();
    checked_count_o  <= checked;
  end

endmodule

// ===== tb/sv/batch_insertion_sorter_tb.sv =====
// Top of the batch insertion sorter testbench: clock, reset, stimulus and verdict.
module batch_insertion_sorter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bis_pkg::*;

  typedef enum int {FullRange, NarrowRange, EdgeValues} spread_e;

  localparam value_t MaxVal  = 32'sh7fff_ffff;
  localparam value_t MinVal  = 32'sh8000_0000;
  localparam int     HoldLen = 300;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic [31:0] value      = '0;
  logic        batch_end  = 1'b0;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [31:0] sorted_value;
  logic        last_out;
  logic        overflowed;

  int mismatches;
  int due;
  int checked;

  int   idle_pct      = 0;
  int   stall_pct     = 0;
  logic hold_toggle   = 1'b0;
  logic hold_seen     = 1'b0;
  int   hold_left     = 0;
  int   values_sent   = 0;
  int   batches_sent  = 0;
  int   over_batches  = 0;

  always #1 clk = ~clk;

  batch_insertion_sorter u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .value_i       (value),
    .batch_end_i   (batch_end),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .sorted_value_o(sorted_value),
    .last_out_o    (last_out),
    .overflowed_o  (overflowed)
  );

  sorted_batch_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .value_i         (value),
    .batch_end_i     (batch_end),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .sorted_value_i  (sorted_value),
    .last_out_i      (last_out),
    .overflowed_i    (overflowed),
    .mismatch_count_o(mismatches),
    .due_count_o     (due),
    .checked_count_o (checked)
  );

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = HoldLen;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic value_t pick_value(input spread_e spread);
    value_t v;
    case (spread)
      NarrowRange: v = $signed($urandom_range(6)) - 3;
      EdgeValues: begin
        case ($urandom_range(6))
          0: v = MinVal;
          1: v = MinVal + 1;
          2: v = -1;
          3: v = 0;
          4: v = 1;
          5: v = MaxVal - 1;
          default: v = MaxVal;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // idle cycles after a transaction are drawn per cycle, so idle_pct is the idle share
  task automatic send_value(input value_t v, input logic is_end);
    in_valid  <= 1'b1;
    value     <= v;
    batch_end <= is_end;
    do @(posedge clk); while (!in_ready);
    values_sent++;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic send_batch(input int unsigned n, input spread_e spread);
    for (int unsigned i = 0; i < n; i++)
      send_value(pick_value(spread), i + 1 == n);
    batches_sent++;
    if (n > CAPACITY) over_batches++;
  endtask

  task automatic random_batches(input int unsigned quota);
    int unsigned done;
    int unsigned n;
    int unsigned roll;
    done = 0;
    while (done < quota) begin
      roll = $urandom_range(99);
      if (roll < 10) n = CAPACITY;
      else if (roll < 20) n = CAPACITY + $urandom_range(1, 4);
      else n = $urandom_range(1, CAPACITY - 1);
      send_batch(n, spread_e'($urandom_range(2)));
      done += n;
    end
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    do @(posedge clk); while (due != 0);
  endtask

  task automatic run_phase(input int idle, input int stall, input int unsigned quota);
    idle_pct  = idle;
    stall_pct <= stall;
    random_batches(quota);
    drain_all();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-value batch, then extremes and duplicates
    send_value(MinVal, 1'b1);
    batches_sent++;
    send_value(MaxVal, 1'b0);
    send_value(0, 1'b0);
    send_value(MinVal, 1'b0);
    send_value(5, 1'b0);
    send_value(5, 1'b0);
    send_value(-1, 1'b1);
    batches_sent++;
    // fills the batch; the closing value is dropped
    send_batch(CAPACITY + 1, EdgeValues);
    drain_all();

    run_phase(0, 0, 20);
    run_phase(61, 0, 20);
    run_phase(0, 61, 20);
    run_phase(11, 11, 20);

    // receiver holds off while batches keep coming
    idle_pct  = 0;
    stall_pct <= 0;
    hold_toggle <= ~hold_toggle;
    send_batch(CAPACITY, FullRange);
    send_batch($urandom_range(2, CAPACITY), NarrowRange);
    send_batch(CAPACITY + 2, FullRange);
    drain_all();

    repeat (20) @(posedge clk);
    $display("Sent %0d values in %0d batches (%0d over capacity); %0d sorted results checked.",
             values_sent, batches_sent, over_batches, checked);
    $display("Idle phases: none, sender, receiver, both, and a %0d-cycle receiver hold-off.",
             HoldLen);
    if (mismatches == 0 && due == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== batch_insertion_sorter.f =====
src/bis_pkg.sv
src/bis_cell.sv
src/batch_insertion_sorter.sv
tb/sv/sorted_batch_checker.sv
tb/sv/batch_insertion_sorter_tb.sv
